// ===== rtl/vsfp_pkg.sv =====
package vsfp_pkg;

   // frame store geometry
   localparam int FRAME_BYTES = 64;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int POS_W       = $clog2(FRAME_BYTES + 1);
   localparam int LEN_W       = 17;

   // frame layout
   localparam logic [7:0]  START_BYTE  = 8'h01;
   localparam logic [15:0] TYPE_HEART  = 16'h0A15;
   localparam logic [15:0] TYPE_BREATH = 16'h0A14;
   localparam logic [15:0] TYPE_DIST   = 16'h0A16;
   localparam int          HEADER_LEN  = 7;
   localparam int          PAYLOAD_AT  = 8;
   localparam int          LEN_HI_AT   = 3;
   localparam int          LEN_LO_AT   = 4;
   localparam int          TYPE_HI_AT  = 5;
   localparam int          TYPE_LO_AT  = 6;
   localparam int          SHORT_SUM   = 4;
   localparam int          LONG_SUM    = 8;
   localparam int          NEED_SHORT  = PAYLOAD_AT + SHORT_SUM + 1;
   localparam int          NEED_LONG   = PAYLOAD_AT + LONG_SUM + 1;
   localparam int          SCAN_LAST   = PAYLOAD_AT + LONG_SUM;
   localparam int          SCAN_W      = $clog2(SCAN_LAST + 2);

   // new-value flag bits and the error-clear bit of the clear mask
   localparam int FLAG_HEART  = 0;
   localparam int FLAG_BREATH = 1;
   localparam int FLAG_DIST   = 2;
   localparam int CLR_ERROR   = 3;

   // register map
   localparam int          CSR_ADDR_W     = 3;
   localparam int          CSR_DATA_W     = 32;
   localparam logic [0:0]  REG_BIG_ENDIAN = 1'b0;

   typedef enum logic [2:0] {
      STAT_TAKEN     = 3'd0,
      STAT_NO_UPDATE = 3'd1,
      STAT_HDR_CKSUM = 3'd2,
      STAT_PAY_CKSUM = 3'd3,
      STAT_TOO_LONG  = 3'd4,
      STAT_UNKNOWN   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_HEADER   = 3'd1,
      ERR_PAYLOAD  = 3'd2,
      ERR_OVERFLOW = 3'd3,
      ERR_UNKNOWN  = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/vital_sign_frame_parser.sv =====
// a byte that does not complete a stored frame moves the parser to the emit state, and
// the result beat is registered and offered once the output is free; for the closing
// byte of a frame it first reads back seventeen stored bytes through the single read
// port, then passes the finish state; bytes are taken only in idle, after the beat is loaded
// reset: synchronous, active high; clears frame tracking, stored values, flags, error code
// and the endian register; the frame store keeps its contents and needs no clearing
module vital_sign_frame_parser (
   input  logic                             clock,
   input  logic                             reset,
   // input beats
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_byte_valid,
   input  logic [7:0]                       req_rx_byte,
   input  logic [3:0]                       req_clear_mask,
   // result beats
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_frame_done,
   output logic [2:0]                       rsp_frame_status,
   output logic [2:0]                       rsp_last_error,
   output logic                             rsp_heart_new,
   output logic                             rsp_breath_new,
   output logic                             rsp_distance_new,
   output logic [31:0]                      rsp_heart_bits,
   output logic [31:0]                      rsp_breath_bits,
   output logic [31:0]                      rsp_distance_bits,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [vsfp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [vsfp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [vsfp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import vsfp_pkg::*;

   // control state
   state_type         state_ff, state_in;
   logic              big_endian_ff, big_endian_in;
   logic              in_frame_ff, in_frame_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  exp_ff, exp_in;
   logic [2:0]        flags_ff, flags_in;
   err_type           err_ff, err_in;
   logic [31:0]       heart_ff, heart_in;
   logic [31:0]       breath_ff, breath_in;
   logic [31:0]       dist_ff, dist_in;
   logic [SCAN_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [7:0]        len_hi_ff, len_hi_in;
   logic [7:0]        len_lo_ff, len_lo_in;
   logic              done_ff, done_in;
   status_type        status_ff, status_in;
   logic [7:0]        hx_ff, hx_in;          // running xor of header bytes
   logic [7:0]        hck_ff, hck_in;        // header checksum byte
   logic [7:0]        t_hi_ff, t_hi_in;
   logic [7:0]        t_lo_ff, t_lo_in;
   logic [7:0]        px4_ff, px4_in;        // xor over a one-word payload
   logic [7:0]        px8_ff, px8_in;        // xor over a two-word payload
   logic [7:0]        ck4_ff, ck4_in;
   logic [7:0]        ck8_ff, ck8_in;
   logic [7:0]        pl_ff [8];
   logic [7:0]        pl_in [8];
   logic              rsp_done_ff;
   status_type        rsp_status_ff;
   err_type           rsp_err_ff;
   logic [2:0]        rsp_flags_ff;
   logic [31:0]       rsp_heart_ff, rsp_breath_ff, rsp_dist_ff;

   // frame store and its ports
   logic [7:0]        store_mem [FRAME_BYTES];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        rd_data_ff;

   // decode helpers
   logic              accept;
   logic              out_free;
   logic              go_scan;
   logic              csr_write;
   logic [POS_W-1:0]  pos_nx;
   logic [LEN_W-1:0]  exp_nx;
   logic [SCAN_W-1:0] tag;
   logic [15:0]       frame_type;
   logic [31:0]       word0, word1;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign tag       = cnt_ff - SCAN_W'(1);
   assign frame_type = {t_hi_ff, t_lo_ff};

   // payload words in the configured byte order
   assign word0 = big_endian_ff ? {pl_ff[0], pl_ff[1], pl_ff[2], pl_ff[3]}
                                : {pl_ff[3], pl_ff[2], pl_ff[1], pl_ff[0]};
   assign word1 = big_endian_ff ? {pl_ff[4], pl_ff[5], pl_ff[6], pl_ff[7]}
                                : {pl_ff[7], pl_ff[6], pl_ff[5], pl_ff[4]};

   // register port
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_BIG_ENDIAN) begin
         csr_prdata = CSR_DATA_W'(big_endian_ff);
      end
   end

   always_comb begin
      big_endian_in = big_endian_ff;
      if (csr_write && csr_paddr[CSR_ADDR_W-1:2] == REG_BIG_ENDIAN) begin
         big_endian_in = csr_pwdata[0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = go_scan ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == SCAN_W'(SCAN_LAST + 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      mem_raddr = '0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   mem_raddr = ADDR_W'(cnt_ff);
         ST_FINISH: req_ready = 1'b0;
         ST_EMIT:   req_ready = 1'b0;
         default:   req_ready = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      exp_in      = exp_ff;
      flags_in    = flags_ff;
      err_in      = err_ff;
      heart_in    = heart_ff;
      breath_in   = breath_ff;
      dist_in     = dist_ff;
      cnt_in      = cnt_ff;
      len_hi_in   = len_hi_ff;
      len_lo_in   = len_lo_ff;
      done_in     = done_ff;
      status_in   = status_ff;
      hx_in       = hx_ff;
      hck_in      = hck_ff;
      t_hi_in     = t_hi_ff;
      t_lo_in     = t_lo_ff;
      px4_in      = px4_ff;
      px8_in      = px8_ff;
      ck4_in      = ck4_ff;
      ck8_in      = ck8_ff;
      pl_in       = pl_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      go_scan     = 1'b0;
      pos_nx      = pos_ff + POS_W'(1);
      exp_nx      = exp_ff;

      if (accept) begin
         flags_in  = flags_ff & ~req_clear_mask[2:0];
         if (req_clear_mask[CLR_ERROR]) begin
            err_in = ERR_NONE;
         end
         done_in   = 1'b0;
         status_in = STAT_TAKEN;
         if (req_byte_valid) begin
            if (!in_frame_ff) begin
               if (req_rx_byte == START_BYTE) begin
                  mem_we      = 1'b1;
                  pos_in      = POS_W'(1);
                  in_frame_in = 1'b1;
                  exp_in      = '0;
               end
            end else if (pos_ff < POS_W'(FRAME_BYTES)) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[ADDR_W-1:0];
               pos_in    = pos_nx;
               if (pos_ff == POS_W'(LEN_HI_AT)) begin
                  len_hi_in = req_rx_byte;
               end
               if (pos_ff == POS_W'(LEN_LO_AT)) begin
                  len_lo_in = req_rx_byte;
               end
               if (pos_nx == POS_W'(HEADER_LEN)) begin
                  exp_nx = LEN_W'(PAYLOAD_AT + 1) + {1'b0, len_hi_ff, len_lo_ff};
               end
               exp_in = exp_nx;
               if (pos_nx == POS_W'(HEADER_LEN) && exp_nx > LEN_W'(FRAME_BYTES)) begin
                  // declared longer than the store
                  err_in      = ERR_OVERFLOW;
                  done_in     = 1'b1;
                  status_in   = STAT_TOO_LONG;
                  in_frame_in = 1'b0;
                  pos_in      = '0;
                  exp_in      = '0;
               end else if (exp_nx != '0 && LEN_W'(pos_nx) >= exp_nx) begin
                  // last byte stored, read the frame back
                  go_scan = 1'b1;
                  cnt_in  = '0;
                  hx_in   = '0;
                  px4_in  = '0;
                  px8_in  = '0;
               end
            end else begin
               // store already full
               err_in      = ERR_OVERFLOW;
               done_in     = 1'b1;
               status_in   = STAT_TOO_LONG;
               in_frame_in = 1'b0;
               pos_in      = '0;
               exp_in      = '0;
            end
         end
      end

      if (state_ff == ST_SCAN) begin
         cnt_in = cnt_ff + SCAN_W'(1);
         if (cnt_ff != '0) begin
            if (tag < SCAN_W'(HEADER_LEN)) begin
               hx_in = hx_ff ^ rd_data_ff;
            end
            if (tag == SCAN_W'(HEADER_LEN)) begin
               hck_in = rd_data_ff;
            end
            if (tag == SCAN_W'(TYPE_HI_AT)) begin
               t_hi_in = rd_data_ff;
            end
            if (tag == SCAN_W'(TYPE_LO_AT)) begin
               t_lo_in = rd_data_ff;
            end
            if (tag >= SCAN_W'(PAYLOAD_AT) && tag < SCAN_W'(PAYLOAD_AT + LONG_SUM)) begin
               pl_in[tag[2:0]] = rd_data_ff;
               px8_in          = px8_ff ^ rd_data_ff;
            end
            if (tag >= SCAN_W'(PAYLOAD_AT) && tag < SCAN_W'(PAYLOAD_AT + SHORT_SUM)) begin
               px4_in = px4_ff ^ rd_data_ff;
            end
            if (tag == SCAN_W'(PAYLOAD_AT + SHORT_SUM)) begin
               ck4_in = rd_data_ff;
            end
            if (tag == SCAN_W'(PAYLOAD_AT + LONG_SUM)) begin
               ck8_in = rd_data_ff;
            end
         end
      end

      if (state_ff == ST_FINISH) begin
         done_in     = 1'b1;
         in_frame_in = 1'b0;
         pos_in      = '0;
         exp_in      = '0;
         priority if (~hx_ff != hck_ff) begin
            err_in    = ERR_HEADER;
            status_in = STAT_HDR_CKSUM;
         end else if (frame_type == TYPE_HEART || frame_type == TYPE_BREATH) begin
            if (exp_ff < LEN_W'(NEED_SHORT) || ~px4_ff != ck4_ff) begin
               err_in    = ERR_PAYLOAD;
               status_in = STAT_PAY_CKSUM;
            end else begin
               err_in    = ERR_NONE;
               status_in = STAT_TAKEN;
               if (frame_type == TYPE_HEART) begin
                  heart_in             = word0;
                  flags_in[FLAG_HEART] = 1'b1;
               end else begin
                  breath_in             = word0;
                  flags_in[FLAG_BREATH] = 1'b1;
               end
            end
         end else if (frame_type == TYPE_DIST) begin
            if (exp_ff < LEN_W'(NEED_LONG) || ~px8_ff != ck8_ff) begin
               err_in    = ERR_PAYLOAD;
               status_in = STAT_PAY_CKSUM;
            end else begin
               err_in = ERR_NONE;
               if (word0 == 32'd1) begin
                  status_in           = STAT_TAKEN;
                  dist_in             = word1;
                  flags_in[FLAG_DIST] = 1'b1;
               end else begin
                  // flag word says no target
                  status_in = STAT_NO_UPDATE;
               end
            end
         end else begin
            err_in    = ERR_UNKNOWN;
            status_in = STAT_UNKNOWN;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         big_endian_ff <= 1'b0;
         in_frame_ff   <= 1'b0;
         pos_ff        <= '0;
         exp_ff        <= '0;
         flags_ff      <= '0;
         err_ff        <= ERR_NONE;
         heart_ff      <= '0;
         breath_ff     <= '0;
         dist_ff       <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         big_endian_ff <= big_endian_in;
         in_frame_ff   <= in_frame_in;
         pos_ff        <= pos_in;
         exp_ff        <= exp_in;
         flags_ff      <= flags_in;
         err_ff        <= err_in;
         heart_ff      <= heart_in;
         breath_ff     <= breath_in;
         dist_ff       <= dist_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, snapshot of the sticky state taken when the beat is loaded
   always_ff @(posedge clock) begin
      len_hi_ff <= len_hi_in;
      len_lo_ff <= len_lo_in;
      done_ff   <= done_in;
      status_ff <= status_in;
      hx_ff     <= hx_in;
      hck_ff    <= hck_in;
      t_hi_ff   <= t_hi_in;
      t_lo_ff   <= t_lo_in;
      px4_ff    <= px4_in;
      px8_ff    <= px8_in;
      ck4_ff    <= ck4_in;
      ck8_ff    <= ck8_in;
      pl_ff     <= pl_in;
      if (state_ff == ST_EMIT && out_free) begin
         rsp_done_ff   <= done_ff;
         rsp_status_ff <= status_ff;
         rsp_err_ff    <= err_ff;
         rsp_flags_ff  <= flags_ff;
         rsp_heart_ff  <= heart_ff;
         rsp_breath_ff <= breath_ff;
         rsp_dist_ff   <= dist_ff;
      end
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= req_rx_byte;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_done    = rsp_done_ff;
   assign rsp_frame_status  = rsp_status_ff;
   assign rsp_last_error    = rsp_err_ff;
   assign rsp_heart_new     = rsp_flags_ff[FLAG_HEART];
   assign rsp_breath_new    = rsp_flags_ff[FLAG_BREATH];
   assign rsp_distance_new  = rsp_flags_ff[FLAG_DIST];
   assign rsp_heart_bits    = rsp_heart_ff;
   assign rsp_breath_bits   = rsp_breath_ff;
   assign rsp_distance_bits = rsp_dist_ff;

   // checks
   a_status_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_done || rsp_frame_status == STAT_TAKEN))
      else $error("status reported without frame end");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(FRAME_BYTES))
      else $error("byte position beyond store");

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (pos_ff == '0 && exp_ff == '0))
      else $error("frame tracking left over while hunting");

   a_scan_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (in_frame_ff && !req_ready))
      else $error("read-back outside a frame");

   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (state_ff == ST_SCAN || state_ff == ST_FINISH))
      else $error("read-back left early");

endmodule
